FILE: rtl/liferle_pkg.sv
// ----------------------------------------------------------------------------
// liferle_pkg
// Shared types and constants for the RLE pattern decoder: character codes,
// result kinds and the result record passed between stages.
// ----------------------------------------------------------------------------
package liferle_pkg;

  // Widths of the result fields and of a character code
  localparam int RUN_W = 16;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_RUN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_LIVE  = 8'h6F;  // 'o'
  localparam logic [CHAR_W-1:0] CH_DEAD  = 8'h62;  // 'b'
  localparam logic [CHAR_W-1:0] CH_EOL   = 8'h24;  // '$'
  localparam logic [CHAR_W-1:0] CH_END   = 8'h21;  // '!'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;  // newline
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;  // first control whitespace
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;  // last control whitespace
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Run count saturation
  localparam logic [RUN_W-1:0] COUNT_MAX = 16'hFFFF;

  // One decoded result, with a flag telling whether the item produced one
  typedef struct packed {
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [RUN_W-1:0]  run_x;
    logic [RUN_W-1:0]  run_y;
    logic [RUN_W-1:0]  run_length;
  } res_t;

endpackage

FILE: rtl/liferle_if.sv
// ----------------------------------------------------------------------------
// liferle_if
// Valid/ready channels of the decoder: the character input and the run
// result output.
// ----------------------------------------------------------------------------
interface liferle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       new_file;

  modport source (output valid, output char_code, output new_file, input ready);
  modport sink   (input valid, input char_code, input new_file, output ready);
endinterface

interface liferle_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] run_x;
  logic [15:0] run_y;
  logic [15:0] run_length;

  modport source (output valid, output kind, output run_x, output run_y,
                  output run_length, input ready);
  modport sink   (input valid, input kind, input run_x, input run_y,
                  input run_length, output ready);
endinterface

FILE: rtl/liferle_in_stage.sv
// ----------------------------------------------------------------------------
// liferle_in_stage
// Input register: captures one character per transfer and holds it until the
// decode stage takes it.
// ----------------------------------------------------------------------------
module liferle_in_stage
  import liferle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  liferle_in_if.sink        in_ch,
  input  logic              take,       // decode stage consumes the held item
  output logic              held_vld,
  output logic [CHAR_W-1:0] held_char,
  output logic              held_new
);

  logic              vld_r;
  logic [CHAR_W-1:0] char_r;
  logic              new_r;
  logic              load;

  // Accept when empty or when the held item leaves this cycle
  assign in_ch.ready = !vld_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= in_ch.char_code;
      new_r  <= in_ch.new_file;
    end
  end

  assign held_vld  = vld_r;
  assign held_char = char_r;
  assign held_new  = new_r;

endmodule

FILE: rtl/liferle_core.sv
// ----------------------------------------------------------------------------
// liferle_core
// Decoder state and character decode: header skip, run count gathering,
// cursor updates with saturation, and result generation.
// ----------------------------------------------------------------------------
module liferle_core
  import liferle_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [CHAR_W-1:0] ch,
  input  logic              new_file,
  output res_t              res
);

  localparam int SUM_W = ((COORD_BITS > RUN_W) ? COORD_BITS : RUN_W) + 1;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam int ACC_W = RUN_W + 4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t                phase_r, phase_nxt, ph;
  logic [COORD_BITS-1:0] col_r, col_nxt, col;
  logic [COORD_BITS-1:0] row_r, row_nxt, row;
  logic [RUN_W-1:0]      pend_r, pend_nxt, pend;
  logic                  hasd_r, hasd_nxt, hasd;

  logic [RUN_W-1:0]      count;
  logic [ACC_W-1:0]      acc;
  logic [SUM_W-1:0]      col_sum;
  logic [SUM_W-1:0]      row_sum;
  logic [COORD_BITS-1:0] col_adv;
  logic [COORD_BITS-1:0] row_adv;

  // Restart view of the state when the item opens a new file
  always_comb begin
    ph   = new_file ? PH_HEADER : phase_r;
    col  = new_file ? '0 : col_r;
    row  = new_file ? '0 : row_r;
    pend = new_file ? '0 : pend_r;
    hasd = new_file ? 1'b0 : hasd_r;
  end

  // Count: decimal accumulate, saturating cursor sums
  always_comb begin
    count   = hasd ? pend : RUN_W'(1);
    acc     = ACC_W'({pend, 3'b000}) + ACC_W'({pend, 1'b0}) + ACC_W'(4'(ch - CH_ZERO));
    col_sum = SUM_W'(col) + SUM_W'(count);
    row_sum = SUM_W'(row) + SUM_W'(count);
    col_adv = (col_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : col_sum[COORD_BITS-1:0];
    row_adv = (row_sum > SUM_W'(COORD_MAX)) ? COORD_MAX : row_sum[COORD_BITS-1:0];
  end

  // Decode one character
  always_comb begin
    phase_nxt      = ph;
    col_nxt        = col;
    row_nxt        = row;
    pend_nxt       = pend;
    hasd_nxt       = hasd;
    res            = '0;
    res.kind       = KIND_RUN;
    unique case (ph)
      PH_HEADER: begin
        if (ch == CH_NL) begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        unique case (ch) inside
          [CH_ZERO:CH_NINE]: begin
            pend_nxt = (acc > ACC_W'(COUNT_MAX)) ? COUNT_MAX : acc[RUN_W-1:0];
            hasd_nxt = 1'b1;
          end
          CH_SPACE, [CH_TAB:CH_CR]: begin
          end
          CH_LIVE: begin
            pend_nxt = '0;
            hasd_nxt = 1'b0;
            if (count != '0) begin
              col_nxt        = col_adv;
              res.emit       = 1'b1;
              res.kind       = KIND_RUN;
              res.run_x      = RUN_W'(col);
              res.run_y      = RUN_W'(row);
              res.run_length = count;
            end
          end
          CH_DEAD: begin
            col_nxt  = col_adv;
            pend_nxt = '0;
            hasd_nxt = 1'b0;
          end
          CH_EOL: begin
            row_nxt  = row_adv;
            col_nxt  = '0;
            pend_nxt = '0;
            hasd_nxt = 1'b0;
          end
          CH_END: begin
            phase_nxt = PH_DONE;
            pend_nxt  = '0;
            hasd_nxt  = 1'b0;
            res.emit  = 1'b1;
            res.kind  = KIND_END;
          end
          default: begin
            phase_nxt = PH_ERROR;
            pend_nxt  = '0;
            hasd_nxt  = 1'b0;
            res.emit  = 1'b1;
            res.kind  = KIND_ERR;
          end
        endcase
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
      end
    endcase
  end

  // Hold decoder state; advance once per consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
      hasd_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
      hasd_r  <= hasd_nxt;
    end
  end

endmodule

FILE: rtl/liferle_out_stage.sv
// ----------------------------------------------------------------------------
// liferle_out_stage
// Result register: holds one result until the sink takes it and tells the
// input stage when the held character may be consumed.
// ----------------------------------------------------------------------------
module liferle_out_stage
  import liferle_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          held_vld,
  input  res_t          res,
  output logic          take,
  liferle_out_if.source out_ch
);

  logic              vld_r;
  logic [KIND_W-1:0] kind_r;
  logic [RUN_W-1:0]  x_r;
  logic [RUN_W-1:0]  y_r;
  logic [RUN_W-1:0]  len_r;

  // Consume the held item when the result slot is free or drains now
  assign take = held_vld && (!vld_r || out_ch.ready);

  // Hold result valid until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= res.emit;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (take && res.emit) begin
      kind_r <= res.kind;
      x_r    <= res.run_x;
      y_r    <= res.run_y;
      len_r  <= res.run_length;
    end
  end

  assign out_ch.valid      = vld_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.run_x      = x_r;
  assign out_ch.run_y      = y_r;
  assign out_ch.run_length = len_r;

endmodule

FILE: rtl/life_rle_pattern_decoder.sv
// ----------------------------------------------------------------------------
// life_rle_pattern_decoder
// Streaming decoder for RLE cell pattern files, one byte per transfer.
// ----------------------------------------------------------------------------
// Accepts one character per clock cycle, sustained while the sink takes each held
// result, and stalls when a held result is not taken: the character sits in an input
// register, is decoded against the cursor and run count state, and its result lands
// in an output register. The state update loop (count accumulate, saturating
// cursor add) sets the rate. Live runs come out as kind 0 with start column, row
// and length; '!' gives kind 1 and a bad character kind 2, after which the
// decoder stays silent until new_file. Column and row saturate at 2**COORD_BITS-1
// and are reported in 16 bits.
module life_rle_pattern_decoder
  import liferle_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  liferle_in_if.sink    in_ch,
  liferle_out_if.source out_ch
);

  logic              take;
  logic              held_vld;
  logic [CHAR_W-1:0] held_char;
  logic              held_new;
  res_t              res;

  // Input register
  liferle_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .take      (take),
    .held_vld  (held_vld),
    .held_char (held_char),
    .held_new  (held_new)
  );

  // Decode and state
  liferle_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .ch       (held_char),
    .new_file (held_new),
    .res      (res)
  );

  // Result register
  liferle_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .held_vld (held_vld),
    .res      (res),
    .take     (take),
    .out_ch   (out_ch)
  );

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RLE pattern decoder. Feeds pattern files one
// byte per transfer, predicts each run, end and error result from its own
// model of the cursor and count state, and compares them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import liferle_pkg::*;

  localparam int COORD_BITS = 16;
  localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 1;
  localparam int ITEM_TARGET = 750;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_DONE,
    PH_ERROR
  } parse_phase_e;

  logic clk;
  logic rst_n;

  liferle_in_if  in_ch();
  liferle_out_if out_ch();

  life_rle_pattern_decoder #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Decoder shadow state
  longint unsigned cur_col;
  longint unsigned cur_row;
  int unsigned     run_count_acc;
  logic            count_seen;
  parse_phase_e    parse_phase;

  res_t        expected_results[$];
  int unsigned chars_sent;
  int unsigned body_chars;
  int unsigned files_seen;
  int unsigned runs_seen;
  int unsigned ends_seen;
  int unsigned errors_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned sink_stall;
  bit          gaps_on;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pattern prediction
  // --------------------------------------------------------------------------
  function automatic void clear_decoder();
    cur_col       = 0;
    cur_row       = 0;
    run_count_acc = 0;
    count_seen    = 1'b0;
    parse_phase   = PH_HEADER;
  endfunction

  function automatic longint unsigned sat_coord(longint unsigned base, int unsigned step);
    longint unsigned sum;
    sum = base + step;
    return (sum > COORD_MAX) ? COORD_MAX : sum;
  endfunction

  // Append one predicted result to the tail of the queue
  function automatic void enqueue_expected(res_t r);
    expected_results = {expected_results, r};
  endfunction

  // Advance the shadow state by one byte; return the result it causes
  function automatic res_t decode_char(logic [CHAR_W-1:0] c, logic restart);
    res_t        r;
    int unsigned cnt;
    r = '0;
    if (restart) begin
      clear_decoder();
    end
    if (parse_phase == PH_HEADER) begin
      if (c == CH_NL) begin
        parse_phase = PH_BODY;
      end
      return r;
    end
    if (parse_phase != PH_BODY) begin
      return r;
    end
    body_chars++;

    // Gather digits, saturating the count
    if (c >= CH_ZERO && c <= CH_NINE) begin
      cnt = run_count_acc * 10 + (c - CH_ZERO);
      run_count_acc = (cnt > COUNT_MAX) ? COUNT_MAX : cnt;
      count_seen = 1'b1;
      return r;
    end
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      return r;
    end

    cnt = count_seen ? run_count_acc : 1;
    run_count_acc = 0;
    count_seen = 1'b0;
    case (c)
      CH_LIVE: begin
        if (cnt != 0) begin
          r.emit       = 1'b1;
          r.kind       = KIND_RUN;
          r.run_x      = cur_col[RUN_W-1:0];
          r.run_y      = cur_row[RUN_W-1:0];
          r.run_length = cnt[RUN_W-1:0];
          cur_col = sat_coord(cur_col, cnt);
        end
      end
      CH_DEAD: begin
        cur_col = sat_coord(cur_col, cnt);
      end
      CH_EOL: begin
        cur_row = sat_coord(cur_row, cnt);
        cur_col = 0;
      end
      CH_END: begin
        parse_phase = PH_DONE;
        r.emit = 1'b1;
        r.kind = KIND_END;
      end
      default: begin
        parse_phase = PH_ERROR;
        r.emit = 1'b1;
        r.kind = KIND_ERR;
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      clear_decoder();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        chars_sent++;
        if (in_ch.new_file) begin
          files_seen++;
        end
        want = decode_char(in_ch.char_code, in_ch.new_file);
        if (want.emit) begin
          enqueue_expected(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        sink_stall = gaps_on ? $urandom_range(0, 15) : 0;
        got            = '0;
        got.emit       = 1'b1;
        got.kind       = out_ch.kind;
        got.run_x      = out_ch.run_x;
        got.run_y      = out_ch.run_y;
        got.run_length = out_ch.run_length;
        case (got.kind)
          KIND_RUN: runs_seen++;
          KIND_END: ends_seen++;
          default:  errors_seen++;
        endcase
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind=%0d x=%0d y=%0d len=%0d",
                                  got.kind, got.run_x, got.run_y, got.run_length));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.run_x !== want.run_x ||
              got.run_y !== want.run_y || got.run_length !== want.run_length) begin
            note_mismatch($sformatf(
              "expected kind=%0d x=%0d y=%0d len=%0d, got kind=%0d x=%0d y=%0d len=%0d",
              want.kind, want.run_x, want.run_y, want.run_length,
              got.kind, got.run_x, got.run_y, got.run_length));
          end
        end
      end
    end
  end

  // Hold off the result channel for the drawn number of cycles
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      out_ch.ready <= 1'b0;
      sink_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_char(logic [CHAR_W-1:0] c, logic restart = 1'b0);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.new_file  <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_text(string s, bit restart);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], restart && i == 0);
    end
  endtask

  // Drop valid and hold until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Header bytes with '!' and a bad byte, whitespace inside counts,
  // zero counts, a count dropped by '!', silence after the end
  task automatic test_header_and_commands();
    send_text("!#\n", 1'b1);
    send_text("1 \t2o0o0b0$$bo5!o", 1'b0);
  endtask

  // Count saturation, column and row saturation
  task automatic test_saturation();
    send_text("\n99999b2o99999$$o", 1'b1);
  endtask

  // Extreme bad bytes, silence after an error, restart in mid-body
  task automatic test_bad_bytes();
    send_char(CH_NL, 1'b1);
    send_char(8'hFF);
    send_char(CH_LIVE);
    send_text("\n3o", 1'b1);
    send_char(8'h00);
    send_text("\n2b", 1'b1);
    send_text("#\n2o!", 1'b1);
  endtask

  task automatic send_count();
    int unsigned pick;
    int unsigned digits;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      digits = 0;
    end else if (pick < 85) begin
      digits = 1;
    end else if (pick < 95) begin
      digits = $urandom_range(2, 3);
    end else begin
      digits = $urandom_range(4, 6);
    end
    for (int i = 0; i < digits; i++) begin
      send_char(CHAR_W'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 19) == 0) begin
        send_char(($urandom_range(0, 6) == 6) ? CH_SPACE :
                  CHAR_W'(CH_TAB + $urandom_range(0, 4)));
      end
    end
  endtask

  // One file: random header, mostly well-formed runs, some noise
  task automatic send_random_file();
    int unsigned       hdr_len;
    int unsigned       tokens;
    int unsigned       pick;
    logic [CHAR_W-1:0] b;
    hdr_len = $urandom_range(0, 5);
    for (int i = 0; i < hdr_len; i++) begin
      b = CHAR_W'($urandom_range(0, 255));
      if (b == CH_NL) begin
        b = CH_END;
      end
      send_char(b, i == 0);
    end
    send_char(CH_NL, hdr_len == 0);

    tokens = $urandom_range(1, 24);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_char(CHAR_W'($urandom_range(0, 255)));
      end else if (pick < 5) begin
        return;
      end else begin
        send_count();
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          send_char(CH_LIVE);
        end else if (pick < 8) begin
          send_char(CH_DEAD);
        end else begin
          send_char(CH_EOL);
        end
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send_count();
      send_char(CH_END);
    end
    repeat ($urandom_range(0, 3)) send_char(CHAR_W'($urandom_range(0, 255)));
  endtask

  task automatic test_random_files();
    int unsigned file_idx;
    file_idx = 0;
    while (chars_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_file();
      if (file_idx % 8 == 7) begin
        wait_drained();
      end
      file_idx++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.new_file  = 1'b0;
    out_ch.ready    = 1'b0;
    gaps_on         = 1'b1;
    sink_stall      = 0;
    quiet_cycles    = 0;
    chars_sent      = 0;
    body_chars      = 0;
    files_seen      = 0;
    runs_seen       = 0;
    ends_seen       = 0;
    errors_seen     = 0;
    mismatches      = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_header_and_commands();
    test_saturation();
    test_bad_bytes();
    test_random_files();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d files, %0d characters of which %0d in pattern bodies",
             files_seen, chars_sent, body_chars);
    $display("checked %0d live runs, %0d pattern ends, %0d format errors; %0d mismatches",
             runs_seen, ends_seen, errors_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
